### hw/rtl/tick_task_scheduler_assert.svh
// ----------------------------------------------------------------------------
// tick task scheduler assertion macros
// shared property wrappers for the checker, clocked on clk
// ----------------------------------------------------------------------------
`ifndef TICK_TASK_SCHEDULER_ASSERT_SVH
`define TICK_TASK_SCHEDULER_ASSERT_SVH

// property checked outside reset
`define TTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also covers the reset cycles
`define TTS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// constants and types shared by the tick task scheduler files
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int NUM_TASKS = 8;
  localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 3;
  localparam int CNT_W   = 16;

  typedef logic [OP_W-1:0]   opcode_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam opcode_t OP_TICK   = 2'd0;
  localparam opcode_t OP_CREATE = 2'd1;
  localparam opcode_t OP_DELETE = 2'd2;
  localparam opcode_t OP_CLEAR  = 2'd3;

  typedef struct packed {
    cnt_t delay;
    cnt_t count;
    logic periodic;
  } entry_t;

endpackage

### hw/rtl/tts_cmd_if.sv
// ----------------------------------------------------------------------------
// tts_cmd_if
// command channel into the scheduler: operation and task fields
// ----------------------------------------------------------------------------
interface tts_cmd_if
  import tts_pkg::*;
;
  logic    valid;
  logic    ready;
  opcode_t opcode;
  slot_t   task_slot;
  cnt_t    delay;
  cnt_t    initial_count;
  logic    periodic;

  modport source (output valid, opcode, task_slot, delay, initial_count, periodic,
                  input ready);
  modport sink   (input valid, opcode, task_slot, delay, initial_count, periodic,
                  output ready);
endinterface

interface tts_evt_if
  import tts_pkg::*;
;
  logic  valid;
  logic  ready;
  logic  fired;
  slot_t fired_slot;
  logic  status;
  logic  last;

  modport source (output valid, fired, fired_slot, status, last, input ready);
  modport sink   (input valid, fired, fired_slot, status, last, output ready);
endinterface

### hw/rtl/tick_task_scheduler.sv
// ----------------------------------------------------------------------------
// tick_task_scheduler
// priority indexed task table; ticks advance counters and report firings
// ----------------------------------------------------------------------------
// cmd carries one operation per transaction: tick, create, delete or clear.
// evt carries the results: one per firing task in ascending slot order, the
// final one marked last, or a single status result when a tick finds no task.
// create, delete and clear give no result.
// a tick with tasks walks the slot memory one slot per cycle while the walk
// is not held, the slot read registered ahead of the compare and write back;
// cmd is ready again only after the walk and the flush; the first result is
// registered when the second firing is found, or at the end of the walk.
// results sit in an output register; a stalled evt holds the walk only when
// a further firing has to be pushed, otherwise the walk continues.
// reset empties the table at once (valid marks only) and drops any result.
// ----------------------------------------------------------------------------
module tick_task_scheduler
  import tts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tts_cmd_if.sink    cmd,
  tts_evt_if.source  evt
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_FLUSH = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;

  logic [2:0]           state, state_next;
  idx_t                 idx, idx_next;
  logic [NUM_TASKS-1:0] valid;
  logic                 pend_valid;
  idx_t                 pend_slot;

  entry_t               mem [NUM_TASKS];
  entry_t               rd;
  logic                 we;
  idx_t                 wa;
  entry_t               wd;

  logic                 out_valid, out_fired, out_status, out_last;
  slot_t                out_slot;

  logic                 push, push_ok, push_fired, push_status, push_last;
  slot_t                push_slot;
  logic                 accept, slot_ok, hit, adv, idx_end;
  idx_t                 cmd_idx;
  cnt_t                 cnt_inc;

  assign accept  = cmd.valid && cmd.ready;
  assign cmd_idx = IDX_W'(cmd.task_slot);
  assign slot_ok = 32'(cmd.task_slot) < NUM_TASKS;
  assign push_ok = !out_valid || evt.ready;
  assign cnt_inc = rd.count + 16'd1;
  assign hit     = valid[idx] && (cnt_inc == rd.delay);
  assign adv     = !hit || !pend_valid || push_ok;
  assign idx_end = idx == IDX_W'(NUM_TASKS - 1);

  assign cmd.ready      = (state == ST_IDLE) && !rst;
  assign evt.valid      = out_valid;
  assign evt.fired      = out_fired;
  assign evt.fired_slot = out_slot;
  assign evt.status     = out_status;
  assign evt.last       = out_last;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    we          = 1'b0;
    wa          = idx;
    wd          = rd;
    push        = 1'b0;
    push_fired  = 1'b1;
    push_slot   = SLOT_W'(pend_slot);
    push_status = 1'b0;
    push_last   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.opcode)
            OP_TICK: begin
              idx_next   = '0;
              state_next = (|valid) ? ST_CHECK : ST_EMPTY;
            end
            OP_CREATE: begin
              we = slot_ok;
              wa = cmd_idx;
              wd = '{delay: cmd.delay, count: cmd.initial_count,
                     periodic: cmd.periodic};
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (adv) begin
          we = valid[idx];
          wa = idx;
          wd = '{delay: rd.delay, count: hit ? '0 : cnt_inc, periodic: rd.periodic};
          push = hit && pend_valid;
          if (idx_end) begin
            state_next = ST_FLUSH;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        push      = pend_valid && push_ok;
        push_last = 1'b1;
        if (!pend_valid || push_ok) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        push        = push_ok;
        push_fired  = 1'b0;
        push_slot   = '0;
        push_status = 1'b1;
        push_last   = 1'b1;
        if (push_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // slot memory, read registered from the next index ahead of the compare
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      valid      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (state == ST_IDLE && accept) begin
        case (cmd.opcode)
          OP_CREATE: if (slot_ok) valid[cmd_idx] <= 1'b1;
          OP_DELETE: if (slot_ok) valid[cmd_idx] <= 1'b0;
          OP_CLEAR:  valid <= '0;
          default:   ;
        endcase
      end
      if (state == ST_CHECK && adv && hit) begin
        pend_valid <= 1'b1;
        if (!rd.periodic) begin
          valid[idx] <= 1'b0;
        end
      end
      if (state == ST_FLUSH && state_next == ST_IDLE) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK && adv && hit) begin
      pend_slot <= idx;
    end
    if (push) begin
      out_fired  <= push_fired;
      out_slot   <= push_slot;
      out_status <= push_status;
      out_last   <= push_last;
    end
  end

endmodule

### hw/rtl/tts_checker.sv
// ----------------------------------------------------------------------------
// tts_checker
// port level checks on the scheduler result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "tick_task_scheduler_assert.svh"

module tts_checker
  import tts_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  evt_valid,
  input logic  evt_ready,
  input logic  evt_fired,
  input slot_t evt_fired_slot,
  input logic  evt_status,
  input logic  evt_last
);

  `TTS_ASSERT(a_evt_hold, evt_valid && !evt_ready |=> evt_valid && $stable(evt_fired) && $stable(evt_fired_slot) && $stable(evt_status) && $stable(evt_last), "stalled transaction changed")
  `TTS_ASSERT(a_fire_ok, evt_valid && evt_fired |-> !evt_status, "firing with empty status")
  `TTS_ASSERT(a_empty_form, evt_valid && evt_status |-> evt_last && !evt_fired && evt_fired_slot == '0, "malformed empty status")
  `TTS_ASSERT(a_kind, evt_valid && !evt_fired |-> evt_status, "result neither firing nor status")
  `TTS_ASSERT_RST(a_rst_quiet, rst |=> !evt_valid, "result present after reset")

endmodule

bind tick_task_scheduler tts_checker u_tts_checker (
  .clk            (clk),
  .rst            (rst),
  .evt_valid      (evt.valid),
  .evt_ready      (evt.ready),
  .evt_fired      (evt.fired),
  .evt_fired_slot (evt.fired_slot),
  .evt_status     (evt.status),
  .evt_last       (evt.last)
);
